// ===== sv/iate_pkg.sv =====
`timescale 1ns / 1ps

package iate_pkg;

   localparam int DEFAULT_STORE_DEPTH = 16;

   localparam int ACTION_W   = 3;
   localparam int POSITION_W = 4;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int FOUND_W    = 5;
   localparam int COUNT_W    = 5;

   localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd6;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   localparam logic signed [FOUND_W-1:0] NOT_FOUND = '1;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_INSERT,
      CELL_DELETE
   } cell_kind_type;

   typedef struct packed {
      cell_kind_type     kind;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ===== sv/iate_req_if.sv =====
`timescale 1ns / 1ps

interface iate_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic [3:0]         position;
   logic signed [31:0] item_value;

   modport source (output valid, action, position, item_value, input ready);
   modport sink (input valid, action, position, item_value, output ready);
endinterface

// ===== sv/iate_rsp_if.sv =====
`timescale 1ns / 1ps

interface iate_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] read_value;
   logic signed [4:0]  found_position;
   logic [4:0]         element_count;
   logic               empty_flag;

   modport source (output valid, status, read_value, found_position, element_count,
                   empty_flag, input ready);
   modport sink (input valid, status, read_value, found_position, element_count,
                 empty_flag, output ready);
endinterface

// ===== sv/iate_cell.sv =====
`timescale 1ns / 1ps

module iate_cell #(
   parameter int STORE_DEPTH = iate_pkg::DEFAULT_STORE_DEPTH,
   parameter int IDX         = 0
) (
   input  logic                                clock,
   input  iate_pkg::cell_cmd_type              cmd,
   input  logic [$clog2(STORE_DEPTH)-1:0]      pos,
   input  logic [iate_pkg::DATA_W-1:0]         left_data,
   input  logic [iate_pkg::DATA_W-1:0]         right_data,
   output logic [iate_pkg::DATA_W-1:0]         data
);
   import iate_pkg::*;

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.kind)
         CELL_WRITE: begin
            if (pos == MY_IDX) data_in = cmd.value;
         end
         CELL_INSERT: begin
            if (pos == MY_IDX) data_in = cmd.value;
            else if (MY_IDX > pos) data_in = left_data;
         end
         CELL_DELETE: begin
            if (MY_IDX >= pos) data_in = right_data;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

// ===== sv/indexed_array_table_engine.sv =====
`timescale 1ns / 1ps
// Push, pop, read, insert and delete go straight from the transfer into the result register,
// one request per cycle while the result side keeps up.
// Remove and find step through the cells one index per cycle, holding the index
// on a removed element; result back-pressure stalls the scan, and no new request
// is taken until the scan ends.
// Synchronous active-high reset empties the list; cell contents are not reset.
module indexed_array_table_engine #(
   parameter int STORE_DEPTH = iate_pkg::DEFAULT_STORE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   iate_req_if.sink   req_chan,
   iate_rsp_if.source rsp_chan
);
   import iate_pkg::*;

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STORE_DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                 state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     scan_k_ff, scan_k_in;
   logic [ACTION_W-1:0]  act_ff, act_in;
   logic [DATA_W-1:0]    val_ff, val_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [DATA_W-1:0]    rsp_read_ff;
   logic [FOUND_W-1:0]   rsp_found_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_empty_ff;

   logic                 rsp_free;
   logic                 req_fire;
   logic                 produce;
   logic [STATUS_W-1:0]  st;
   logic [DATA_W-1:0]    rd;
   logic [FOUND_W-1:0]   found;
   logic [CMP_W-1:0]     pos_cmp, cnt_cmp;
   logic [IDX_W-1:0]     sel_idx;
   logic [DATA_W-1:0]    sel_data;

   cell_cmd_type         cmd;
   logic [IDX_W-1:0]     cmd_pos;
   logic [DATA_W-1:0]    cell_data [STORE_DEPTH];

   for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = cmd.value;
      end else begin : g_mid
         assign left_d = cell_data[i-1];
      end
      if (i == STORE_DEPTH - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_body
         assign right_d = cell_data[i+1];
      end
      iate_cell #(
         .STORE_DEPTH (STORE_DEPTH),
         .IDX         (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos        (cmd_pos),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i])
      );
   end

   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && rsp_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign pos_cmp        = CMP_W'(req_chan.position);
   assign cnt_cmp        = CMP_W'(count_ff);

   always_comb begin
      if (state_ff == S_SCAN) sel_idx = IDX_W'(scan_k_ff);
      else if (req_chan.action == ACT_POP) sel_idx = IDX_W'(count_ff - CNT_W'(1));
      else sel_idx = IDX_W'(req_chan.position);
   end
   assign sel_data = cell_data[sel_idx];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      scan_k_in = scan_k_ff;
      act_in    = act_ff;
      val_in    = val_ff;
      cmd.kind  = CELL_HOLD;
      cmd.value = req_chan.item_value;
      cmd_pos   = IDX_W'(req_chan.position);
      produce   = 1'b0;
      st        = STAT_OK;
      rd        = '0;
      found     = NOT_FOUND;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_chan.action)
                  ACT_PUSH: begin
                     produce = 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        st = STAT_FULL;
                     end else begin
                        cmd.kind = CELL_WRITE;
                        cmd_pos  = IDX_W'(count_ff);
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_POP: begin
                     produce = 1'b1;
                     if (count_ff == '0) begin
                        st = STAT_RANGE;
                     end else begin
                        rd       = sel_data;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_READ: begin
                     produce = 1'b1;
                     if (pos_cmp >= cnt_cmp) st = STAT_RANGE;
                     else rd = sel_data;
                  end
                  ACT_INSERT: begin
                     produce = 1'b1;
                     if (pos_cmp > cnt_cmp) begin
                        st = STAT_RANGE;
                     end else if (count_ff == FULL_COUNT) begin
                        st = STAT_FULL;
                     end else begin
                        cmd.kind = CELL_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_DELETE: begin
                     produce = 1'b1;
                     if (pos_cmp >= cnt_cmp) begin
                        st = STAT_RANGE;
                     end else begin
                        cmd.kind = CELL_DELETE;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  ACT_REMOVE, ACT_FIND: begin
                     state_in  = S_SCAN;
                     scan_k_in = '0;
                     act_in    = req_chan.action;
                     val_in    = req_chan.item_value;
                  end
                  default: begin
                     produce = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmd_pos = IDX_W'(scan_k_ff);
            if (rsp_free) begin
               if (scan_k_ff == count_ff) begin
                  produce  = 1'b1;
                  state_in = S_IDLE;
               end else if (sel_data == val_ff) begin
                  if (act_ff == ACT_FIND) begin
                     produce  = 1'b1;
                     found    = FOUND_W'(scan_k_ff);
                     state_in = S_IDLE;
                  end else begin
                     cmd.kind = CELL_DELETE;
                     count_in = count_ff - CNT_W'(1);
                  end
               end else begin
                  scan_k_in = scan_k_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = produce ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_k_ff <= scan_k_in;
      act_ff    <= act_in;
      val_ff    <= val_in;
      if (produce) begin
         rsp_status_ff <= st;
         rsp_read_ff   <= rd;
         rsp_found_ff  <= found;
         rsp_count_ff  <= COUNT_W'(count_in);
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.read_value     = rsp_read_ff;
   assign rsp_chan.found_position = rsp_found_ff;
   assign rsp_chan.element_count  = rsp_count_ff;
   assign rsp_chan.empty_flag     = rsp_empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("element count above capacity");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> scan_k_ff <= count_ff)
      else $error("scan index beyond element count");

   a_scan_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> !req_chan.ready)
      else $error("request taken during scan");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.action == ACT_PUSH && count_ff != FULL_COUNT
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not grow the list");
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import iate_pkg::*;

   localparam int DEPTH = DEFAULT_STORE_DEPTH;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic signed [DATA_W-1:0]  read_value;
      logic signed [FOUND_W-1:0] found_position;
      logic [COUNT_W-1:0]        element_count;
      logic                      empty_flag;
   } list_result_type;

   class list_tracker_type;
      logic signed [DATA_W-1:0] cells[DEPTH];
      int                       held;
      list_result_type          pending_results[$];
      int                       mismatches;
      int                       requests;
      int                       results;
      int                       full_refusals;
      int                       range_refusals;
      int                       find_hits;

      function void drop_cell(int idx);
         for (int k = idx; k + 1 < held; k++) cells[k] = cells[k + 1];
         held--;
      endfunction

      function void note_request(logic [ACTION_W-1:0] action,
                                 logic [POSITION_W-1:0] position,
                                 logic signed [DATA_W-1:0] item_value);
         list_result_type want;
         int              k;
         want.status         = STAT_OK;
         want.read_value     = '0;
         want.found_position = NOT_FOUND;
         case (action)
            ACT_PUSH: begin
               if (held >= DEPTH) want.status = STAT_FULL;
               else begin
                  cells[held] = item_value;
                  held++;
               end
            end
            ACT_POP: begin
               if (held == 0) want.status = STAT_RANGE;
               else begin
                  held--;
                  want.read_value = cells[held];
               end
            end
            ACT_READ: begin
               if (int'(position) >= held) want.status = STAT_RANGE;
               else want.read_value = cells[position];
            end
            ACT_INSERT: begin
               if (int'(position) > held) want.status = STAT_RANGE;
               else if (held >= DEPTH) want.status = STAT_FULL;
               else begin
                  for (k = held; k > int'(position); k--) cells[k] = cells[k - 1];
                  cells[position] = item_value;
                  held++;
               end
            end
            ACT_DELETE: begin
               if (int'(position) >= held) want.status = STAT_RANGE;
               else drop_cell(int'(position));
            end
            ACT_REMOVE: begin
               k = 0;
               while (k < held) begin
                  if (cells[k] == item_value) drop_cell(k);
                  else k++;
               end
            end
            ACT_FIND: begin
               for (k = 0; k < held; k++) begin
                  if (cells[k] == item_value) begin
                     want.found_position = 5'(k);
                     find_hits++;
                     break;
                  end
               end
            end
            default: ;
         endcase
         want.element_count = 5'(held);
         want.empty_flag    = (held == 0);
         if (want.status == STAT_FULL) full_refusals++;
         if (want.status == STAT_RANGE) range_refusals++;
         requests++;
         pending_results.push_back(want);
      endfunction

      task report(string msg);
         $display("[%0t] result %0d: %s", $realtime, results, msg);
         mismatches++;
      endtask

      task check_result(logic [STATUS_W-1:0] status, logic signed [DATA_W-1:0] read_value,
                        logic signed [FOUND_W-1:0] found_position,
                        logic [COUNT_W-1:0] element_count, logic empty_flag);
         list_result_type want;
         if (pending_results.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = pending_results.pop_front();
         if (status !== want.status)
            report($sformatf("status got %0d want %0d", status, want.status));
         if (read_value !== want.read_value)
            report($sformatf("read_value got %0d want %0d", read_value, want.read_value));
         if (found_position !== want.found_position)
            report($sformatf("found_position got %0d want %0d", found_position,
                             want.found_position));
         if (element_count !== want.element_count)
            report($sformatf("element_count got %0d want %0d", element_count,
                             want.element_count));
         if (empty_flag !== want.empty_flag)
            report($sformatf("empty_flag got %0b want %0b", empty_flag, want.empty_flag));
         results++;
      endtask
   endclass

   logic             clock;
   logic             reset;
   bit               quiet;
   list_tracker_type book;

   iate_req_if req_if ();
   iate_rsp_if rsp_if ();

   indexed_array_table_engine #(
      .STORE_DEPTH(DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return -32'sd1;
         3, 4, 5: return 32'($urandom_range(0, 3));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(logic [ACTION_W-1:0] act, logic [POSITION_W-1:0] pos,
                               logic signed [DATA_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.action     <= act;
      req_if.position   <= pos;
      req_if.item_value <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      book.note_request(act, pos, val);
   endtask

   // result side: random back-pressure
   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         book.check_result(rsp_if.status, rsp_if.read_value, rsp_if.found_position,
                           rsp_if.element_count, rsp_if.empty_flag);
   end

   initial begin
      #1_000_000;
      $display("timeout with %0d responses outstanding", book.pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [ACTION_W-1:0]      act;
      logic [POSITION_W-1:0]    pos;
      logic signed [DATA_W-1:0] val;
      bit                       grow;
      int                       r;
      int                       top;

      book              = new();
      reset             <= 1'b1;
      quiet             <= 1'b0;
      req_if.valid      <= 1'b0;
      req_if.action     <= ACT_PUSH;
      req_if.position   <= '0;
      req_if.item_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corner cases
      send_request(ACT_POP, 4'd0, 32'sd0);
      send_request(ACT_READ, 4'd0, 32'sd0);
      send_request(ACT_DELETE, 4'd0, 32'sd0);
      send_request(ACT_FIND, 4'd0, -32'sd1);
      send_request(ACT_REMOVE, 4'd0, 32'sd0);
      send_request(ACT_INSERT, 4'd1, 32'sd5);
      send_request(ACT_INSERT, 4'd0, 32'sh7fff_ffff);
      // fill to capacity
      send_request(ACT_PUSH, 4'hf, 32'sh8000_0000);
      for (int i = 0; i < DEPTH - 2; i++) send_request(ACT_PUSH, 4'($urandom), pick_value());
      send_request(ACT_PUSH, 4'd0, 32'sd1);
      send_request(ACT_INSERT, 4'd15, 32'sd2);
      send_request(ACT_READ, 4'd15, 32'sd0);
      send_request(ACT_FIND, 4'd0, 32'sh8000_0000);
      send_request(ACT_REMOVE, 4'd0, 32'sh8000_0000);
      send_request(ACT_DELETE, 4'd0, 32'sd0);
      send_request(ACT_INSERT, 4'd1, -32'sd1);
      send_request(ACT_UNUSED, 4'hf, -32'sd1);
      send_request(ACT_POP, 4'd0, 32'sd0);

      for (int n = 0; n < 700; n++) begin
         grow  = ((n / 50) % 2) == 0;
         quiet <= ((n / 90) % 4) == 3;
         r = $urandom_range(0, 99);
         if (r < (grow ? 55 : 15))
            act = $urandom_range(0, 1) ? ACT_PUSH : ACT_INSERT;
         else if (r < 70)
            act = $urandom_range(0, 1) ? ACT_POP : ACT_DELETE;
         else if (r < 78)
            act = ACT_REMOVE;
         else if (r < 97)
            act = $urandom_range(0, 1) ? ACT_READ : ACT_FIND;
         else
            act = ACT_UNUSED;

         top = (act == ACT_INSERT) ? book.held : book.held - 1;
         if (top > 15) top = 15;
         if (top >= 0 && $urandom_range(0, 99) < 85)
            pos = POSITION_W'($urandom_range(0, top));
         else
            pos = POSITION_W'($urandom_range(0, 15));

         if (book.held > 0 && (act == ACT_FIND || act == ACT_REMOVE) &&
             $urandom_range(0, 99) < 60)
            val = book.cells[$urandom_range(0, book.held - 1)];
         else
            val = pick_value();
         send_request(act, pos, val);
      end
      req_if.valid <= 1'b0;
      quiet        <= 1'b0;

      while (book.pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (book.pending_results.size() != 0) book.report("responses never arrived");

      $display("covered %0d requests, %0d responses checked, %0d find hits",
               book.requests, book.results, book.find_hits);
      $display("refusals seen: %0d on a full list, %0d for range or empty list",
               book.full_refusals, book.range_refusals);
      if (book.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
